### sv/sssr_pkg.sv
// sssr_pkg: shared types, constants and helpers of the stream substring replace block.
// No dependencies; compile first.
package sssr_pkg;

    localparam int CHAR_W     = 16;   // width of a character on the ports
    localparam int CFG_DATA_W = 64;   // widest configuration register
    localparam int CFG_IDX_W  = 3;    // configuration register index
    localparam int LANES      = 8;    // characters per pattern/replacement register pair
    localparam int LEN_W      = 4;    // pattern/replacement length registers

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW      = 3'd0,
        CFG_PATTERN_HIGH     = 3'd1,
        CFG_PATTERN_LENGTH   = 3'd2,
        CFG_REPLACEMENT_LOW  = 3'd3,
        CFG_REPLACEMENT_HIGH = 3'd4,
        CFG_REPLACEMENT_LEN  = 3'd5,
        CFG_REPLACE_LIMIT    = 3'd6,
        CFG_LIMIT_ENABLED    = 3'd7
    } cfg_index_t;

    // One result item as held in an output cell.
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              last_out;
    } out_entry_t;

    // Window cell control.
    typedef struct packed {
        logic append;   // this cell is the next free slot
        logic write;    // take the next value
    } win_ctrl_t;

    // Output cell control.
    typedef struct packed {
        logic load;     // parallel load of a new burst
        logic shift;    // take the neighbor's contents
    } out_ctrl_t;

    // Character k of a low/high register pair, char 0 in the low bits of lo.
    function automatic logic [CHAR_W-1:0] lane_char(input logic [CFG_DATA_W-1:0] lo,
                                                    input logic [CFG_DATA_W-1:0] hi,
                                                    input logic [2:0]            k);
        logic [CFG_DATA_W-1:0] w;
        w = k[2] ? hi : lo;
        return w[k[1:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

### sv/sssr_stream_if.sv
// Stream interfaces of the stream substring replace block: character input and result output.
// Depends on sssr_pkg.
interface sssr_char_if;
    logic                         valid;
    logic                         ready;
    logic [sssr_pkg::CHAR_W-1:0]  in_char;
    logic                         end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface sssr_result_if;
    logic                         valid;
    logic                         ready;
    logic [sssr_pkg::CHAR_W-1:0]  out_char;
    logic                         char_valid;
    logic                         last_out;

    modport source (output valid, output out_char, output char_valid, output last_out,
                    input ready);
    modport sink   (input valid, input out_char, input char_valid, input last_out,
                    output ready);
endinterface

### sv/sssr_win_cell.sv
// sssr_win_cell: one character slot of the match window, with its pattern compare.
// Depends on sssr_pkg.
module sssr_win_cell #(
    parameter int W = 16
) (
    input  logic                clk,
    input  sssr_pkg::win_ctrl_t ctrl,
    input  logic [W-1:0]        append_char,
    input  logic [W-1:0]        pat_char,
    input  logic [W-1:0]        char_next,
    output logic [W-1:0]        view_char,
    output logic                eq
);

    logic [W-1:0] char_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            char_reg <= char_next;
        end
    end

    // contents as seen after this cycle's append
    assign view_char = ctrl.append ? append_char : char_reg;
    assign eq        = (view_char == pat_char);

endmodule

### sv/sssr_out_cell.sv
// sssr_out_cell: one slot of the result chain; loads in parallel, drains toward the head.
// Depends on sssr_pkg.
module sssr_out_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sssr_pkg::out_ctrl_t  ctrl,
    input  logic                 load_occ,
    input  sssr_pkg::out_entry_t load_entry,
    input  logic                 nbr_occ,
    input  sssr_pkg::out_entry_t nbr_entry,
    output logic                 occ,
    output sssr_pkg::out_entry_t entry
);

    logic                 occ_reg, occ_next;
    sssr_pkg::out_entry_t entry_reg, entry_next;

    always_comb
    begin
        occ_next   = occ_reg;
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            occ_next   = load_occ;
            entry_next = load_entry;
        end
        else if (ctrl.shift)
        begin
            occ_next   = nbr_occ;
            entry_next = nbr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign occ   = occ_reg;
    assign entry = entry_reg;

endmodule

### sv/stream_substring_replace_core.sv
// stream_substring_replace_core: streaming find-and-replace on characters. Text enters one
// item per cycle on char_stream when ready, end_of_text on the final character; leftmost
// non-overlapping occurrences of the pattern (1..8 chars) are replaced by the replacement
// (0..8 chars), optionally at most replace_limit times per text. The window is a row of
// cells that each hold one character and compare it to their pattern character, so the
// decision for an item is made in the cycle it is accepted. Its results are loaded into a
// row of eight output cells that drain one item per cycle on result_stream when ready. An
// item is taken whenever the output row will hold nothing after the current cycle, so the
// rate is one item per cycle while each item yields at most one result and output is
// ready; one with several results (a replacement or the end-of-text flush) holds the input
// until they drain, one with none (window filling, deleted match) does not. No clearing
// pass after reset; the user must write configuration only between items (not enforced).
// Depends on sssr_pkg, sssr_stream_if, sssr_win_cell, sssr_out_cell.
module stream_substring_replace_core #(
    parameter int PATTERN_MAX     = 8,
    parameter int REPLACEMENT_MAX = 8,
    parameter int CHAR_BITS       = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [sssr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sssr_pkg::CFG_DATA_W-1:0]   cfg_data,
    sssr_char_if.sink                         char_stream,
    sssr_result_if.source                     result_stream
);

    localparam int LANES    = sssr_pkg::LANES;
    localparam int LEN_W    = sssr_pkg::LEN_W;
    // stored character width: port width, narrowed by CHAR_BITS
    localparam int CW       = (CHAR_BITS < sssr_pkg::CHAR_W) ? CHAR_BITS : sssr_pkg::CHAR_W;
    localparam int FILL_W   = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W    = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam int PLEN_CAP = (PATTERN_MAX < LANES) ? PATTERN_MAX : LANES;
    localparam int RLEN_CAP = (REPLACEMENT_MAX < LANES) ? REPLACEMENT_MAX : LANES;

    // ---------------------------------------------------------------- configuration
    logic [sssr_pkg::CFG_DATA_W-1:0] pattern_low_reg, pattern_high_reg;
    logic [sssr_pkg::CFG_DATA_W-1:0] replacement_low_reg, replacement_high_reg;
    logic [LEN_W-1:0]                pattern_length_reg, replacement_length_reg;
    logic [15:0]                     replace_limit_reg;
    logic                            limit_enabled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg        <= '0;
            pattern_high_reg       <= '0;
            pattern_length_reg     <= LEN_W'(1);
            replacement_low_reg    <= '0;
            replacement_high_reg   <= '0;
            replacement_length_reg <= '0;
            replace_limit_reg      <= '0;
            limit_enabled_reg      <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (sssr_pkg::cfg_index_t'(cfg_index))
                sssr_pkg::CFG_PATTERN_LOW:      pattern_low_reg        <= cfg_data;
                sssr_pkg::CFG_PATTERN_HIGH:     pattern_high_reg       <= cfg_data;
                sssr_pkg::CFG_PATTERN_LENGTH:   pattern_length_reg     <= cfg_data[LEN_W-1:0];
                sssr_pkg::CFG_REPLACEMENT_LOW:  replacement_low_reg    <= cfg_data;
                sssr_pkg::CFG_REPLACEMENT_HIGH: replacement_high_reg   <= cfg_data;
                sssr_pkg::CFG_REPLACEMENT_LEN:  replacement_length_reg <= cfg_data[LEN_W-1:0];
                sssr_pkg::CFG_REPLACE_LIMIT:    replace_limit_reg      <= cfg_data[15:0];
                sssr_pkg::CFG_LIMIT_ENABLED:    limit_enabled_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective lengths: pattern clamped to 1..PLEN_CAP, replacement to 0..RLEN_CAP
    logic [LEN_W-1:0] plen_eff, rlen_eff;

    always_comb
    begin
        plen_eff = pattern_length_reg;
        if (plen_eff == '0)
        begin
            plen_eff = LEN_W'(1);
        end
        if (plen_eff > LEN_W'(PLEN_CAP))
        begin
            plen_eff = LEN_W'(PLEN_CAP);
        end
        rlen_eff = replacement_length_reg;
        if (rlen_eff > LEN_W'(RLEN_CAP))
        begin
            rlen_eff = LEN_W'(RLEN_CAP);
        end
    end

    // ---------------------------------------------------------------- handshakes
    logic             in_acc, pop;
    logic [LANES-1:0] occ_vec;

    assign in_acc = char_stream.valid && char_stream.ready;
    assign pop    = result_stream.valid && result_stream.ready;

    // take an item only if the output row is empty after this cycle
    assign char_stream.ready = !occ_vec[1] && (!occ_vec[0] || result_stream.ready);

    // ---------------------------------------------------------------- window cells
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       done_reg, done_next;
    logic [CW-1:0]     in_masked;
    logic [CW-1:0]     view      [PATTERN_MAX];
    logic [CW-1:0]     pat_char  [PATTERN_MAX];
    logic [CW-1:0]     win_next  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq;

    assign in_masked = char_stream.in_char[CW-1:0];

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_win
        sssr_pkg::win_ctrl_t     wctrl;
        logic [sssr_pkg::CHAR_W-1:0] lane_full;

        if (i < LANES)
        begin : g_lane
            assign lane_full = sssr_pkg::lane_char(pattern_low_reg, pattern_high_reg, 3'(i));
        end
        else
        begin : g_nolane
            assign lane_full = '0;
        end

        assign pat_char[i]  = lane_full[CW-1:0];
        assign wctrl.append = (fill_reg == FILL_W'(i));
        assign wctrl.write  = in_acc;

        sssr_win_cell #(
            .W (CW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (wctrl),
            .append_char (in_masked),
            .pat_char    (pat_char[i]),
            .char_next   (win_next[i]),
            .view_char   (view[i]),
            .eq          (eq[i])
        );
    end

    // ---------------------------------------------------------------- decision
    logic [CNT_W-1:0] fill_app, plen_c;
    logic             last_in, decide, allowed, all_eq, match;

    assign last_in  = char_stream.end_of_text;
    assign fill_app = CNT_W'(fill_reg) + CNT_W'(fill_reg < FILL_W'(PATTERN_MAX));
    assign plen_c   = CNT_W'(plen_eff);
    assign decide   = last_in ? (fill_app == plen_c) : (fill_app >= plen_c);
    assign allowed  = !(limit_enabled_reg && (done_reg >= replace_limit_reg));

    always_comb
    begin
        all_eq = 1'b1;
        for (int k = 0; k < PLEN_CAP; k++)
        begin
            if ((LEN_W'(k) < plen_eff) && !eq[k])
            begin
                all_eq = 1'b0;
            end
        end
    end

    assign match = decide && allowed && all_eq;

    // window shift: by pattern length on a match, by one on a plain decision
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            win_next[i] = view[i];
            if (match)
            begin
                for (int j = 1; j <= PLEN_CAP; j++)
                begin
                    if ((plen_eff == LEN_W'(j)) && (i + j < PATTERN_MAX))
                    begin
                        win_next[i] = view[i + j];
                    end
                end
            end
            else if (decide && (i + 1 < PATTERN_MAX))
            begin
                win_next[i] = view[i + 1];
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        done_next = done_reg;
        if (in_acc)
        begin
            if (last_in)
            begin
                fill_next = '0;
                done_next = '0;
            end
            else
            begin
                if (match)
                begin
                    fill_next = FILL_W'(fill_app - plen_c);
                    if (done_reg != 16'hFFFF)
                    begin
                        done_next = done_reg + 16'd1;
                    end
                end
                else if (decide)
                begin
                    fill_next = FILL_W'(fill_app - CNT_W'(1));
                end
                else
                begin
                    fill_next = FILL_W'(fill_app);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= done_next;
        end
    end

    // ---------------------------------------------------------------- result burst
    sssr_pkg::out_entry_t burst [LANES];
    logic [LEN_W-1:0]     burst_cnt;

    always_comb
    begin
        logic [sssr_pkg::CHAR_W-1:0] rch;
        for (int k = 0; k < LANES; k++)
        begin
            rch = sssr_pkg::lane_char(replacement_low_reg, replacement_high_reg, 3'(k));
            burst[k].char_valid = 1'b1;
            burst[k].last_out   = 1'b0;
            if (match)
            begin
                burst[k].out_char = sssr_pkg::CHAR_W'(rch[CW-1:0]);
            end
            else if (k < PATTERN_MAX)
            begin
                burst[k].out_char = sssr_pkg::CHAR_W'(view[k]);
            end
            else
            begin
                burst[k].out_char = '0;
            end
        end

        if (match)
        begin
            burst_cnt = rlen_eff;
        end
        else if (last_in)
        begin
            // flush of the whole window, at most one row of results
            burst_cnt = (fill_app > CNT_W'(LANES)) ? LEN_W'(LANES) : LEN_W'(fill_app);
        end
        else
        begin
            burst_cnt = LEN_W'(decide);
        end

        // end of text with nothing to say: one end-only marker
        if (last_in && (burst_cnt == '0))
        begin
            burst_cnt           = LEN_W'(1);
            burst[0].out_char   = '0;
            burst[0].char_valid = 1'b0;
        end

        for (int k = 0; k < LANES; k++)
        begin
            if (last_in && (LEN_W'(k + 1) == burst_cnt))
            begin
                burst[k].last_out = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- output cells
    sssr_pkg::out_entry_t entry [LANES];
    sssr_pkg::out_ctrl_t  octrl;

    assign octrl.load  = in_acc;
    assign octrl.shift = pop;

    for (genvar k = 0; k < LANES; k++)
    begin : g_out
        logic                 nbr_occ;
        sssr_pkg::out_entry_t nbr_entry;

        if (k + 1 < LANES)
        begin : g_mid
            assign nbr_occ   = occ_vec[k + 1];
            assign nbr_entry = entry[k + 1];
        end
        else
        begin : g_tail
            assign nbr_occ   = 1'b0;
            assign nbr_entry = '0;
        end

        sssr_out_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (octrl),
            .load_occ   (LEN_W'(k) < burst_cnt),
            .load_entry (burst[k]),
            .nbr_occ    (nbr_occ),
            .nbr_entry  (nbr_entry),
            .occ        (occ_vec[k]),
            .entry      (entry[k])
        );
    end

    assign result_stream.valid      = occ_vec[0];
    assign result_stream.out_char   = entry[0].out_char;
    assign result_stream.char_valid = entry[0].char_valid;
    assign result_stream.last_out   = entry[0].last_out;

    // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
    // occupied output cells always form a run from the head
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + 1'b1) & occ_vec) == '0)
        else $error("output cells not contiguous");

    // a window never fills completely between items
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(PATTERN_MAX))
        else $error("window fill out of range");

    // end of text always produces a result and returns the state to empty
    a_eot_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last_in) |=> (occ_vec[0] && (fill_reg == '0) && (done_reg == '0)))
        else $error("end of text not flushed");

    // the final result of a text is the last occupied cell
    a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec[0] && entry[0].last_out) |-> !occ_vec[1])
        else $error("results queued behind last_out");
`endif

endmodule
